@@ src/tsd_pkg.sv @@
// Shared types and constants for the trace stream deframer.
// Has no dependencies; the deframer core refers to it by scoped names.
package tsd_pkg;

    // Header layout.
    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned HASH_BYTES   = 8;
    localparam logic [15:0] MAGIC        = {8'h50, 8'h4C};  // 'P', 'L'

    // Byte tags carried on the kind field.
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_HASH   = 3'd1;
    localparam logic [2:0] KIND_TEXT   = 3'd2;
    localparam logic [2:0] KIND_EVENT  = 3'd3;
    localparam logic [2:0] KIND_CTRL   = 3'd4;
    localparam logic [2:0] KIND_DROP   = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EVENT_RECORD_BYTES = 3'd0;
    localparam logic [2:0] CFG_CODE_STRING        = 3'd1;
    localparam logic [2:0] CFG_CODE_EVENT         = 3'd2;
    localparam logic [2:0] CFG_CODE_EVENT_AUX     = 3'd3;
    localparam logic [2:0] CFG_CODE_CONTROL       = 3'd4;

    // One tagged output item.
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       element_end;
        logic       batch_end;
        logic       collection_tick;
        logic       unknown_type;
        logic       error_flag;
    } t_result;

endpackage

@@ src/trace_stream_deframer_core.sv @@
// Trace stream deframer core: tags each byte of a trace stream by section.
// Depends on tsd_pkg for the result type, kind codes and register indexes.
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  --------------------------------------
//  input     in         i_valid / o_stall         i_data_in
//  output    out        o_valid / i_stall         o_data_out, o_kind, o_element_end,
//                                                 o_batch_end, o_collection_tick,
//                                                 o_unknown_type, o_error_flag
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_stall is low; its result is registered in
// the output register, or the skid register while the output is held. The parse
// state updates in the accept cycle, so a byte depends on its predecessor with no
// bubble. A two-entry output (result register plus skid register) keeps o_stall
// registered, so one more byte enters the skid register once the output stalls. Reset
// is synchronous: it clears parse state and output valids, presets config registers.
module trace_stream_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_in,
    // Tagged output stream.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_data_out,
    output logic [2:0]  o_kind,
    output logic        o_element_end,
    output logic        o_batch_end,
    output logic        o_collection_tick,
    output logic        o_unknown_type,
    output logic        o_error_flag,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Section codes of the parser.
    localparam logic [1:0] SEC_HEADER  = 2'd0;
    localparam logic [1:0] SEC_STRING  = 2'd1;
    localparam logic [1:0] SEC_EVENT   = 2'd2;
    localparam logic [1:0] SEC_CONTROL = 2'd3;

    localparam logic [3:0] HDR_LAST  = 4'(tsd_pkg::HEADER_BYTES);
    localparam logic [5:0] HASH_LAST = 6'(tsd_pkg::HASH_BYTES);

    // Configuration registers.
    logic [5:0]  r_erb;
    logic [15:0] r_code_string;
    logic [15:0] r_code_event;
    logic [15:0] r_code_aux;
    logic [15:0] r_code_ctrl;

    // Parse state.
    logic [3:0]  r_fill,    n_fill;
    logic [55:0] r_hdr,     n_hdr;
    logic [1:0]  r_section, n_section;
    logic [31:0] r_left,    n_left;
    logic [5:0]  r_pos,     n_pos;
    logic        r_tick,    n_tick;
    logic        r_failed,  n_failed;

    // Output stage.
    logic                 r_out_valid;
    logic                 r_skid_valid;
    tsd_pkg::t_result     r_out;
    tsd_pkg::t_result     r_skid;
    tsd_pkg::t_result     w_res;

    logic in_acc;
    logic take_out;

    assign o_stall     = r_skid_valid;
    assign in_acc      = i_valid && !r_skid_valid;
    assign take_out    = r_out_valid && !i_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erb         <= 6'd24;
            r_code_string <= 16'd0;
            r_code_event  <= 16'd1;
            r_code_aux    <= 16'd2;
            r_code_ctrl   <= 16'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tsd_pkg::CFG_EVENT_RECORD_BYTES: r_erb         <= i_cfg_data[5:0];
                tsd_pkg::CFG_CODE_STRING:        r_code_string <= i_cfg_data;
                tsd_pkg::CFG_CODE_EVENT:         r_code_event  <= i_cfg_data;
                tsd_pkg::CFG_CODE_EVENT_AUX:     r_code_aux    <= i_cfg_data;
                tsd_pkg::CFG_CODE_CONTROL:       r_code_ctrl   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next parse state and the result for the byte on the input.
    always_comb begin
        logic [3:0]  fill_inc;
        logic [15:0] magic;
        logic [15:0] type_code;
        logic [31:0] count;
        logic [1:0]  next_sec;
        logic        ticks;
        logic        unknown;
        logic [5:0]  pos_inc;
        logic [31:0] left_dec;

        fill_inc  = r_fill + 4'd1;
        magic     = r_hdr[55:40];
        type_code = r_hdr[39:24];
        count     = {r_hdr[23:0], i_data_in};
        pos_inc   = r_pos + 6'd1;
        left_dec  = r_left - 32'd1;
        next_sec  = SEC_HEADER;
        ticks     = 1'b0;
        unknown   = 1'b0;

        n_fill    = r_fill;
        n_hdr     = r_hdr;
        n_section = r_section;
        n_left    = r_left;
        n_pos     = r_pos;
        n_tick    = r_tick;
        n_failed  = r_failed;

        w_res                 = '0;
        w_res.data            = i_data_in;

        if (r_failed) begin
            w_res.kind = tsd_pkg::KIND_DROP;
        end else begin
            case (r_section)
                SEC_HEADER: begin
                    w_res.kind = tsd_pkg::KIND_HEADER;
                    n_hdr      = {r_hdr[47:0], i_data_in};
                    n_fill     = fill_inc;
                    if (fill_inc >= HDR_LAST) begin
                        n_fill            = 4'd0;
                        n_pos             = 6'd0;
                        w_res.element_end = 1'b1;
                        if (magic != tsd_pkg::MAGIC) begin
                            n_failed = 1'b1;
                        end else begin
                            // Type codes match in priority order.
                            if (type_code == r_code_string) begin
                                next_sec = SEC_STRING;
                            end else if (type_code == r_code_event) begin
                                next_sec = SEC_EVENT;
                                ticks    = 1'b1;
                            end else if (type_code == r_code_aux) begin
                                next_sec = SEC_EVENT;
                            end else if (type_code == r_code_ctrl) begin
                                next_sec = SEC_CONTROL;
                            end else begin
                                unknown = 1'b1;
                            end
                            w_res.unknown_type = unknown;
                            if (unknown || count == 32'd0) begin
                                w_res.batch_end       = 1'b1;
                                w_res.collection_tick = ticks;
                                n_section             = SEC_HEADER;
                                n_left                = 32'd0;
                                n_tick                = 1'b0;
                            end else begin
                                n_section = next_sec;
                                n_left    = count;
                                n_tick    = ticks;
                            end
                        end
                    end
                end
                SEC_STRING: begin
                    if (r_pos < HASH_LAST) begin
                        w_res.kind = tsd_pkg::KIND_HASH;
                        n_pos      = pos_inc;
                    end else begin
                        w_res.kind = tsd_pkg::KIND_TEXT;
                        if (i_data_in == 8'd0) begin
                            w_res.element_end = 1'b1;
                            n_pos             = 6'd0;
                            n_left            = left_dec;
                        end
                    end
                end
                SEC_EVENT: begin
                    // A record ends once its byte count reaches the size register.
                    w_res.kind = tsd_pkg::KIND_EVENT;
                    n_pos      = pos_inc;
                    if (pos_inc == 6'd0 || pos_inc >= r_erb) begin
                        w_res.element_end = 1'b1;
                        n_pos             = 6'd0;
                        n_left            = left_dec;
                        if (left_dec == 32'd0 && r_tick) begin
                            w_res.collection_tick = 1'b1;
                            n_tick                = 1'b0;
                        end
                    end
                end
                default: begin
                    w_res.kind        = tsd_pkg::KIND_CTRL;
                    n_left            = left_dec;
                    w_res.element_end = (left_dec == 32'd0);
                end
            endcase

            // Batch closes when the announced count runs out.
            if (!n_failed && n_section != SEC_HEADER && n_left == 32'd0) begin
                w_res.batch_end = 1'b1;
                n_section       = SEC_HEADER;
                n_pos           = 6'd0;
                n_fill          = 4'd0;
            end
        end

        w_res.error_flag = n_failed;
    end

    // Parse state registers advance on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= 4'd0;
            r_hdr     <= '0;
            r_section <= SEC_HEADER;
            r_left    <= 32'd0;
            r_pos     <= 6'd0;
            r_tick    <= 1'b0;
            r_failed  <= 1'b0;
        end else if (in_acc) begin
            r_fill    <= n_fill;
            r_hdr     <= n_hdr;
            r_section <= n_section;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_tick    <= n_tick;
            r_failed  <= n_failed;
        end
    end

    // Output and skid valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take_out || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output and skid payloads.
    always_ff @(posedge i_clk) begin
        if (take_out || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= w_res;
            end
        end else if (in_acc) begin
            r_skid <= w_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_data_out        = r_out.data;
    assign o_kind            = r_out.kind;
    assign o_element_end     = r_out.element_end;
    assign o_batch_end       = r_out.batch_end;
    assign o_collection_tick = r_out.collection_tick;
    assign o_unknown_type    = r_out.unknown_type;
    assign o_error_flag      = r_out.error_flag;

    // The skid register only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output is empty");

    // The magic error lasts until reset.
    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("sticky error cleared without reset");

    // Dropped bytes always carry the error flag.
    a_drop_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == tsd_pkg::KIND_DROP) |-> o_error_flag)
        else $error("dropped byte without error flag");

    // A collection tick only comes with the end of a batch.
    a_tick_ends_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_collection_tick) |-> o_batch_end)
        else $error("collection tick outside a batch end");

endmodule

@@ tb/tb_trace_stream_deframer_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for trace_stream_deframer_core: builds framed trace streams,
// predicts the tag of every byte and compares it with what the block returns.
// Depends on tsd_pkg and the deframer core RTL; needs nothing else.
module tb_trace_stream_deframer_core;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {SEC_HEADER, SEC_STRING, SEC_EVENT, SEC_CONTROL} t_section;

    // Tracks the parse state of the stream and holds the tags still owed by the block.
    class t_byte_tag_tracker;
        logic [5:0]  rec_bytes;
        logic [15:0] code_str, code_evt, code_aux, code_ctl;
        logic [3:0]  hdr_fill;
        logic [63:0] hdr_shift;
        t_section    sect;
        logic [31:0] left;
        logic [5:0]  pos;
        bit          tick_pend;
        bit          failed;
        tsd_pkg::t_result tags_due[$];
        int          n_bytes, n_matched, n_faults;
        int          n_strings, n_records, n_ticks, n_unknown, n_dropped;

        function new();
            rec_bytes = 6'd24;
            code_str  = 16'd0;
            code_evt  = 16'd1;
            code_aux  = 16'd2;
            code_ctl  = 16'd3;
            hdr_fill  = '0;
            hdr_shift = '0;
            sect      = SEC_HEADER;
            left      = '0;
            pos       = '0;
            tick_pend = 0;
            failed    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                tsd_pkg::CFG_EVENT_RECORD_BYTES: rec_bytes = val[5:0];
                tsd_pkg::CFG_CODE_STRING:        code_str  = val;
                tsd_pkg::CFG_CODE_EVENT:         code_evt  = val;
                tsd_pkg::CFG_CODE_EVENT_AUX:     code_aux  = val;
                tsd_pkg::CFG_CODE_CONTROL:       code_ctl  = val;
                default: ;
            endcase
        endfunction

        // Advances the parse state by one accepted byte and queues its tag.
        function void take_byte(logic [7:0] b);
            tsd_pkg::t_result r;
            t_section nxt;
            bit       ticks;
            r = '0;
            r.data = b;
            r.kind = tsd_pkg::KIND_HEADER;
            if (failed) begin
                r.kind = tsd_pkg::KIND_DROP;
                n_dropped++;
            end else if (sect == SEC_HEADER) begin
                hdr_shift = {hdr_shift[55:0], b};
                hdr_fill  = hdr_fill + 4'd1;
                if (hdr_fill >= tsd_pkg::HEADER_BYTES) begin
                    hdr_fill = '0;
                    r.element_end = 1'b1;
                    pos = '0;
                    if (hdr_shift[63:48] != tsd_pkg::MAGIC) begin
                        failed = 1;
                    end else begin
                        // Type codes are matched in fixed priority order.
                        nxt   = SEC_HEADER;
                        ticks = 0;
                        if (hdr_shift[47:32] == code_str) begin
                            nxt = SEC_STRING;
                        end else if (hdr_shift[47:32] == code_evt) begin
                            nxt = SEC_EVENT;
                            ticks = 1;
                        end else if (hdr_shift[47:32] == code_aux) begin
                            nxt = SEC_EVENT;
                        end else if (hdr_shift[47:32] == code_ctl) begin
                            nxt = SEC_CONTROL;
                        end else begin
                            r.unknown_type = 1'b1;
                        end
                        if (r.unknown_type || hdr_shift[31:0] == 32'd0) begin
                            r.batch_end       = 1'b1;
                            r.collection_tick = ticks;
                            sect      = SEC_HEADER;
                            left      = '0;
                            tick_pend = 0;
                        end else begin
                            sect      = nxt;
                            left      = hdr_shift[31:0];
                            tick_pend = ticks;
                        end
                    end
                end
            end else if (sect == SEC_STRING) begin
                if (pos < tsd_pkg::HASH_BYTES) begin
                    r.kind = tsd_pkg::KIND_HASH;
                    pos = pos + 6'd1;
                end else begin
                    r.kind = tsd_pkg::KIND_TEXT;
                    if (b == 8'd0) begin
                        r.element_end = 1'b1;
                        pos  = '0;
                        left = left - 32'd1;
                        n_strings++;
                    end
                end
            end else if (sect == SEC_EVENT) begin
                r.kind = tsd_pkg::KIND_EVENT;
                pos = pos + 6'd1;
                // A record ends once its byte count reaches the size, so zero acts as one.
                if (pos == 6'd0 || pos >= rec_bytes) begin
                    r.element_end = 1'b1;
                    pos  = '0;
                    left = left - 32'd1;
                    n_records++;
                    if (left == 32'd0 && tick_pend) begin
                        r.collection_tick = 1'b1;
                        tick_pend = 0;
                    end
                end
            end else begin
                r.kind = tsd_pkg::KIND_CTRL;
                left = left - 32'd1;
                if (left == 32'd0) r.element_end = 1'b1;
            end

            if (!failed && sect != SEC_HEADER && left == 32'd0) begin
                r.batch_end = 1'b1;
                sect     = SEC_HEADER;
                pos      = '0;
                hdr_fill = '0;
            end
            r.error_flag = failed;
            if (r.collection_tick) n_ticks++;
            if (r.unknown_type) n_unknown++;
            n_bytes++;
            tags_due.insert(tags_due.size(), r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                n_faults++;
                $display("%0t: %s mismatch on byte %0d: expected %0h, actual %0h",
                         $time, name, n_matched, want, got);
            end
        endfunction

        // Compares one returned tag with the oldest one owed.
        function void match_tag(tsd_pkg::t_result got);
            tsd_pkg::t_result want;
            if (tags_due.size() == 0) begin
                n_faults++;
                $display("%0t: item with nothing owed: expected none, actual data %0h kind %0d",
                         $time, got.data, got.kind);
                return;
            end
            want = tags_due.pop_front();
            compare_field("data_out", want.data, got.data);
            compare_field("kind", 8'(want.kind), 8'(got.kind));
            compare_field("element_end", 8'(want.element_end), 8'(got.element_end));
            compare_field("batch_end", 8'(want.batch_end), 8'(got.batch_end));
            compare_field("collection_tick", 8'(want.collection_tick), 8'(got.collection_tick));
            compare_field("unknown_type", 8'(want.unknown_type), 8'(got.unknown_type));
            compare_field("error_flag", 8'(want.error_flag), 8'(got.error_flag));
            n_matched++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_in   = 8'd0;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = tsd_pkg::CFG_EVENT_RECORD_BYTES;
    logic [15:0] i_cfg_data  = 16'd0;
    logic        o_stall, o_valid, o_cfg_ready;
    logic [7:0]  o_data_out;
    logic [2:0]  o_kind;
    logic        o_element_end, o_batch_end, o_collection_tick, o_unknown_type, o_error_flag;

    t_byte_tag_tracker tracker;
    logic [7:0] stream_q[$];
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int cycles        = 0;
    int n_cfg_writes  = 0;
    int ph;

    trace_stream_deframer_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_in         (i_data_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_data_out        (o_data_out),
        .o_kind            (o_kind),
        .o_element_end     (o_element_end),
        .o_batch_end       (o_batch_end),
        .o_collection_tick (o_collection_tick),
        .o_unknown_type    (o_unknown_type),
        .o_error_flag      (o_error_flag),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall: a counted hold-off when one is requested, random otherwise.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Every accepted output item is checked against the oldest owed tag.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.match_tag({o_data_out, o_kind, o_element_end, o_batch_end,
                               o_collection_tick, o_unknown_type, o_error_flag});
        end
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles with %0d tags owed.",
                     cycles, tracker.tags_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one byte after a random idle gap and waits until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_data_in <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_byte(b);
    endtask

    task automatic send_stream();
        while (stream_q.size() > 0) send_byte(stream_q.pop_front());
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every owed tag has come back, then lets the pipeline settle.
    task automatic settle();
        while (tracker.tags_due.size() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_reg(idx, val);
        n_cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [5:0] rec, input logic [15:0] cs, input logic [15:0] ce,
                             input logic [15:0] ca, input logic [15:0] cc);
        write_reg(tsd_pkg::CFG_EVENT_RECORD_BYTES, {10'd0, rec});
        write_reg(tsd_pkg::CFG_CODE_STRING, cs);
        write_reg(tsd_pkg::CFG_CODE_EVENT, ce);
        write_reg(tsd_pkg::CFG_CODE_EVENT_AUX, ca);
        write_reg(tsd_pkg::CFG_CODE_CONTROL, cc);
    endtask

    // Section that a header type selects under the current codes; header means unknown.
    function automatic t_section section_of(logic [15:0] typ);
        if (typ == tracker.code_str) return SEC_STRING;
        if (typ == tracker.code_evt || typ == tracker.code_aux) return SEC_EVENT;
        if (typ == tracker.code_ctl) return SEC_CONTROL;
        return SEC_HEADER;
    endfunction

    function automatic logic [15:0] unknown_code();
        logic [15:0] t;
        do t = 16'($urandom_range(65535)); while (section_of(t) != SEC_HEADER);
        return t;
    endfunction

    // Appends one byte to the stream that is waiting to be sent.
    task automatic queue_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endtask

    task automatic push_random(input int n);
        repeat (n) queue_byte(8'($urandom_range(255)));
    endtask

    task automatic put_header(input logic [15:0] magic, input logic [15:0] typ,
                              input logic [31:0] count);
        queue_byte(magic[15:8]);
        queue_byte(magic[7:0]);
        queue_byte(typ[15:8]);
        queue_byte(typ[7:0]);
        queue_byte(count[31:24]);
        queue_byte(count[23:16]);
        queue_byte(count[15:8]);
        queue_byte(count[7:0]);
    endtask

    // A string is its hash, nonzero text and the terminating zero.
    task automatic put_string(input int text_len);
        push_random(tsd_pkg::HASH_BYTES);
        repeat (text_len) queue_byte(8'($urandom_range(1, 255)));
        queue_byte(8'd0);
    endtask

    // A well-formed batch whose body matches what the type selects.
    task automatic put_batch(input logic [15:0] typ, input logic [31:0] count, input int max_text);
        int rec_eff;
        rec_eff = (tracker.rec_bytes == 6'd0) ? 1 : int'(tracker.rec_bytes);
        put_header(tsd_pkg::MAGIC, typ, count);
        case (section_of(typ))
            SEC_STRING:  repeat (count) put_string($urandom_range(max_text));
            SEC_EVENT:   push_random(int'(count) * rec_eff);
            SEC_CONTROL: push_random(int'(count));
            default: ;
        endcase
    endtask

    task automatic add_random_batch();
        logic [15:0] typ;
        logic [31:0] cnt;
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1:    typ = tracker.code_str;
            2, 3:    typ = tracker.code_evt;
            4, 5:    typ = tracker.code_aux;
            6, 7:    typ = tracker.code_ctl;
            default: typ = unknown_code();
        endcase
        cnt = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
        // Skipped sections may announce any count at all.
        if (pick >= 8 && $urandom_range(1) == 1) cnt = $urandom;
        put_batch(typ, cnt, ($urandom_range(9) == 0) ? 24 : 5);
    endtask

    task automatic run_directed();
        // Strings with extreme hash bytes and an empty text, then the other sections.
        put_header(tsd_pkg::MAGIC, 16'd0, 32'd2);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        push_random(6);
        queue_byte(8'h00);
        put_string(3);
        put_batch(16'd1, 32'd1, 0);
        put_batch(16'd2, 32'd2, 0);
        put_header(tsd_pkg::MAGIC, 16'd3, 32'd3);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h80);
        // Zero counts close the batch on the header; the event one ticks.
        for (int t = 0; t < 4; t++) put_header(tsd_pkg::MAGIC, 16'(t), 32'd0);
        put_header(tsd_pkg::MAGIC, 16'hFFFF, 32'hFFFF_FFFF);
        send_stream();
        settle();

        // Record size lowered below the bytes already taken ends the record at once.
        put_header(tsd_pkg::MAGIC, 16'd1, 32'd2);
        push_random(10);
        send_stream();
        settle();
        write_reg(tsd_pkg::CFG_EVENT_RECORD_BYTES, 16'd4);
        push_random(5);
        send_stream();
        settle();

        // A record size of zero behaves as one byte.
        write_reg(tsd_pkg::CFG_EVENT_RECORD_BYTES, 16'd0);
        put_batch(16'd1, 32'd3, 0);
        send_stream();
        settle();

        // Shared codes: string beats control, event beats aux; then string beats event, aux beats control.
        write_all(6'd2, 16'd9, 16'd5, 16'd5, 16'd9);
        put_batch(16'd9, 32'd1, 2);
        put_batch(16'd5, 32'd2, 0);
        send_stream();
        settle();
        write_all(6'd3, 16'h0040, 16'h0040, 16'h0041, 16'h0041);
        put_batch(16'h0040, 32'd1, 2);
        put_batch(16'h0041, 32'd2, 0);
        put_batch(16'h0042, 32'd1, 0);
        send_stream();
        settle();
    endtask

    initial begin
        int start;
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Random streams under four mixes of sender idling and receiver stalls.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    write_all(6'd1, 16'h0000, 16'h0001, 16'h0002, 16'h0003);
                end
                1: begin
                    send_idle_pct = 68;
                    stall_pct     = 0;
                    write_all(6'd63, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h00FF);
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 68;
                    write_all(6'd0, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535)));
                end
                default: begin
                    send_idle_pct = 37;
                    stall_pct     = 37;
                    write_all(6'd12, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535)));
                end
            endcase
            // A long receiver hold-off while the sender keeps offering fills the block.
            if (ph == 0 || ph == 2) hold_left = 300;
            start = tracker.n_bytes;
            while (tracker.n_bytes - start < 330) begin
                repeat ($urandom_range(1, 3)) add_random_batch();
                send_stream();
                if (ph == 3 && $urandom_range(5) == 0) begin
                    settle();
                    write_reg(tsd_pkg::CFG_EVENT_RECORD_BYTES, 16'($urandom_range(1, 63)));
                end
            end
            settle();
        end

        // A bad magic ends parsing for good; everything after it is dropped.
        send_idle_pct = 20;
        stall_pct     = 20;
        add_random_batch();
        put_header(16'h5058, 16'd1, 32'd1);
        push_random(20);
        send_stream();
        settle();
        repeat (10) @(posedge i_clk);

        $display(
            "Covered %0d bytes: %0d strings, %0d records, %0d ticks, %0d unknown, %0d dropped.",
            tracker.n_matched, tracker.n_strings, tracker.n_records, tracker.n_ticks,
            tracker.n_unknown, tracker.n_dropped);
        $display("It made %0d register writes and saw %0d faults across four stall and idle mixes.",
                 n_cfg_writes, tracker.n_faults);
        if (tracker.n_faults == 0 && tracker.tags_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/tsd_pkg.sv
src/trace_stream_deframer_core.sv
tb/tb_trace_stream_deframer_core.sv
